@@ hw/rtl/utf8d_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Status codes, byte ranges and scalar limits shared by the decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int unsigned ScalarWidth = 21;
  localparam int unsigned StatusWidth = 3;

  typedef logic [ScalarWidth-1:0] scalar_t;
  typedef logic [StatusWidth-1:0] status_t;

  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_BAD_BYTE = 3'd1;
  localparam status_t ST_TRUNC    = 3'd2;
  localparam status_t ST_INVALID  = 3'd3;
  localparam status_t ST_ENDED    = 3'd4;

  localparam logic [7:0] ASCII_MAX = 8'h7F;
  localparam logic [7:0] LEAD2_LO  = 8'hC2;
  localparam logic [7:0] LEAD2_HI  = 8'hDF;
  localparam logic [7:0] LEAD3_LO  = 8'hE0;
  localparam logic [7:0] LEAD3_HI  = 8'hEF;
  localparam logic [7:0] LEAD4_LO  = 8'hF0;
  localparam logic [7:0] LEAD4_HI  = 8'hF4;
  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_TAG  = 8'h80;

  localparam scalar_t MIN2       = 21'h000080;
  localparam scalar_t MIN3       = 21'h000800;
  localparam scalar_t MIN4       = 21'h010000;
  localparam scalar_t SCALAR_MAX = 21'h10FFFF;
  localparam scalar_t SURR_LO    = 21'h00D800;
  localparam scalar_t SURR_HI    = 21'h00DFFF;

  // Length classes of an open sequence.
  localparam logic [1:0] CLS_NONE = 2'd0;
  localparam logic [1:0] CLS_TWO  = 2'd1;
  localparam logic [1:0] CLS_THREE = 2'd2;
  localparam logic [1:0] CLS_FOUR = 2'd3;

endpackage : utf8d_pkg
`default_nettype wire

@@ hw/rtl/utf8_stream_decoder_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 stream decoder unit
// Decodes a byte stream into Unicode scalars, reporting malformed input.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while in_stall is low; the decode is a single
// pass of logic from the input port into the result register.
// A two-entry output (result register and skid register) lets the input
// keep flowing while a result is held; in_stall rises only when both are full.
// Reset is synchronous and returns the decoder to the start of a new text.
module utf8_stream_decoder_unit
  import utf8d_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [7:0]             byte_value,
  input  wire logic                   final_byte,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [ScalarWidth-1:0]      scalar_value,
  output logic [StatusWidth-1:0]      status,
  output logic                        text_done
);

  logic [1:0] bytes_pending, bytes_pending_next;
  scalar_t    partial_value, partial_value_next;
  logic [1:0] length_class, length_class_next;
  logic       bad_continuation_seen, bad_continuation_seen_next;
  logic       aborted, aborted_next;

  logic       res_valid;
  scalar_t    res_value;
  status_t    res_status;

  logic       skid_valid;
  scalar_t    skid_value;
  status_t    skid_status;
  logic       skid_done;

  logic       accept;
  logic       take;

  scalar_t    shifted;
  logic       bad_cont;
  logic [1:0] pending_dec;
  scalar_t    minimum;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign take     = out_valid && !out_stall;

  always_comb begin
    shifted     = {partial_value[ScalarWidth-7:0], byte_value[5:0]};
    bad_cont    = bad_continuation_seen || ((byte_value & CONT_MASK) != CONT_TAG);
    pending_dec = bytes_pending - 2'd1;
    unique case (length_class)
      CLS_TWO:   minimum = MIN2;
      CLS_THREE: minimum = MIN3;
      default:   minimum = MIN4;
    endcase

    res_valid                  = 1'b0;
    res_value                  = '0;
    res_status                 = ST_OK;
    bytes_pending_next         = bytes_pending;
    partial_value_next         = partial_value;
    length_class_next          = length_class;
    bad_continuation_seen_next = bad_continuation_seen;
    aborted_next               = aborted;

    if (aborted) begin
      if (final_byte) begin
        res_valid  = 1'b1;
        res_status = ST_ENDED;
      end
    end else if (bytes_pending == 2'd0) begin
      priority if (byte_value <= ASCII_MAX) begin
        res_valid  = 1'b1;
        res_value  = {{(ScalarWidth-8){1'b0}}, byte_value};
      end else if (byte_value >= LEAD2_LO && byte_value <= LEAD2_HI) begin
        length_class_next  = CLS_TWO;
        partial_value_next = {{(ScalarWidth-5){1'b0}}, byte_value[4:0]};
        bytes_pending_next = 2'd1;
      end else if (byte_value >= LEAD3_LO && byte_value <= LEAD3_HI) begin
        length_class_next  = CLS_THREE;
        partial_value_next = {{(ScalarWidth-4){1'b0}}, byte_value[3:0]};
        bytes_pending_next = 2'd2;
      end else if (byte_value >= LEAD4_LO && byte_value <= LEAD4_HI) begin
        length_class_next  = CLS_FOUR;
        partial_value_next = {{(ScalarWidth-3){1'b0}}, byte_value[2:0]};
        bytes_pending_next = 2'd3;
      end else begin
        res_valid  = 1'b1;
        res_status = ST_BAD_BYTE;
      end
      bad_continuation_seen_next = 1'b0;
      if (!res_valid && final_byte) begin
        res_valid  = 1'b1;
        res_status = ST_TRUNC;
      end
    end else begin
      bad_continuation_seen_next = bad_cont;
      partial_value_next         = shifted;
      bytes_pending_next         = pending_dec;
      if (pending_dec != 2'd0) begin
        if (final_byte) begin
          res_valid  = 1'b1;
          res_status = ST_TRUNC;
        end
      end else begin
        res_valid = 1'b1;
        priority if (bad_cont) begin
          res_status = ST_BAD_BYTE;
        end else if (shifted < minimum || shifted > SCALAR_MAX ||
                     (shifted >= SURR_LO && shifted <= SURR_HI)) begin
          res_status = ST_INVALID;
        end else begin
          res_value = shifted;
        end
      end
    end

    if (res_valid) begin
      bytes_pending_next         = 2'd0;
      partial_value_next         = '0;
      length_class_next          = CLS_NONE;
      bad_continuation_seen_next = 1'b0;
      aborted_next               = !final_byte && (res_status != ST_OK);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending         <= 2'd0;
      partial_value         <= '0;
      length_class          <= CLS_NONE;
      bad_continuation_seen <= 1'b0;
      aborted               <= 1'b0;
    end else if (accept) begin
      bytes_pending         <= bytes_pending_next;
      partial_value         <= partial_value_next;
      length_class          <= length_class_next;
      bad_continuation_seen <= bad_continuation_seen_next;
      aborted               <= aborted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        out_valid    <= 1'b1;
        scalar_value <= skid_value;
        status       <= skid_status;
        text_done    <= skid_done;
        skid_valid   <= 1'b0;
      end else if (accept && res_valid) begin
        out_valid    <= 1'b1;
        scalar_value <= res_value;
        status       <= res_status;
        text_done    <= final_byte;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (accept && res_valid) begin
      if (out_valid) begin
        skid_valid  <= 1'b1;
        skid_value  <= res_value;
        skid_status <= res_status;
        skid_done   <= final_byte;
      end else begin
        out_valid    <= 1'b1;
        scalar_value <= res_value;
        status       <= res_status;
        text_done    <= final_byte;
      end
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("Skid register holds a result while the output register is empty.");

  a_error_zero_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> scalar_value == '0)
    else $error("A failed result carries a non-zero scalar.");

  a_ok_in_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_OK) |->
      (scalar_value <= SCALAR_MAX && !(scalar_value >= SURR_LO && scalar_value <= SURR_HI)))
    else $error("A scalar reported as good lies outside the Unicode range.");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && final_byte) |=> (bytes_pending == 2'd0 && !aborted))
    else $error("Decoder state survives the final word of a text.");

  a_skid_fill_only_when_held: assert property (@(posedge clk) disable iff (rst)
    (!skid_valid && !$past(rst)) ##1 skid_valid |-> $past(out_valid && out_stall))
    else $error("Skid register filled while the output was free.");

endmodule : utf8_stream_decoder_unit
`default_nettype wire
